>>> rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/ctlp_pkg.sv
// Types, constants and field-format functions of the telemetry line parser.
`default_nettype none

package ctlp_pkg;

   localparam int BufBytesDefault = 512;
   localparam int NumFields       = 38;
   localparam int NeedCommas      = 37;

   localparam logic [8:0] CommaMax = 9'd511;

   localparam logic [7:0] CharNul     = 8'h00;
   localparam logic [7:0] CharTab     = 8'h09;
   localparam logic [7:0] CharNewline = 8'h0A;
   localparam logic [7:0] CharCr      = 8'h0D;
   localparam logic [7:0] CharSpace   = 8'h20;
   localparam logic [7:0] CharPlus    = 8'h2B;
   localparam logic [7:0] CharComma   = 8'h2C;
   localparam logic [7:0] CharMinus   = 8'h2D;
   localparam logic [7:0] CharZero    = 8'h30;
   localparam logic [7:0] CharNine    = 8'h39;

   typedef enum logic [1:0] {
      OP_BYTE = 2'd0,
      OP_END  = 2'd1,
      OP_READ = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      FT_U8  = 3'd0,
      FT_U16 = 3'd1,
      FT_S16 = 3'd2,
      FT_S32 = 3'd3,
      FT_U32 = 3'd4
   } field_fmt_type;

   typedef enum logic [2:0] {
      PH_WS   = 3'b001,
      PH_NUM  = 3'b010,
      PH_DONE = 3'b100
   } phase_type;

   function automatic field_fmt_type field_fmt(input logic [5:0] idx);
      field_fmt_type f;
      unique case (idx) inside
         6'd0, 6'd1, 6'd3:  f = FT_U16;
         6'd2:              f = FT_S16;
         6'd4:              f = FT_S32;
         6'd5, 6'd6:        f = FT_U8;
         [6'd7:6'd13]:      f = FT_S16;
         [6'd14:6'd34]:     f = FT_U16;
         6'd35:             f = FT_S16;
         default:           f = FT_U32;
      endcase
      return f;
   endfunction

   function automatic logic [31:0] truncate_value(input logic [31:0] v,
                                                  input field_fmt_type f);
      logic [31:0] r;
      unique case (f)
         FT_U8:          r = {24'd0, v[7:0]};
         FT_U16, FT_S16: r = {16'd0, v[15:0]};
         default:        r = v;
      endcase
      return r;
   endfunction

   function automatic logic [32:0] extend_value(input logic [31:0] v,
                                                input field_fmt_type f);
      logic [32:0] r;
      unique case (f)
         FT_S16:  r = {{17{v[15]}}, v[15:0]};
         FT_S32:  r = {v[31], v};
         default: r = {1'b0, v};
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/csv_telemetry_line_parser_core.sv
// The parser, comma count and commit all act at accept, one item per cycle while
// rsp_ready is high; an accepted line end or read has its result registered on rsp_*.
// Commit flips a per-field bank bit, so no copy of the field store takes place.
// Reset clears the parser state, commit flags and output valid; the field store
// itself is not cleared and needs no clearing pass.
`default_nettype none

module csv_telemetry_line_parser_core #(
   parameter int BUF_BYTES = ctlp_pkg::BufBytesDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_op,
   input  wire logic [7:0]         req_data_byte,
   input  wire logic [5:0]         req_reg_index,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_kind,
   output logic                    rsp_accepted,
   output logic signed [32:0]      rsp_value,
   output logic [5:0]              rsp_read_index
);

   localparam int CntW    = $clog2(BUF_BYTES);
   localparam int NumF    = ctlp_pkg::NumFields;
   localparam int MemD    = 2 * NumF;
   localparam int MemAw   = $clog2(MemD);
   localparam logic [CntW-1:0] ByteLimit = CntW'(BUF_BYTES - 1);

   logic [CntW-1:0]         byte_cnt_ff, byte_cnt_in;
   logic [8:0]              comma_cnt_ff, comma_cnt_in;
   logic [7:0]              last_byte_ff, last_byte_in;
   logic [5:0]              field_ff, field_in;
   ctlp_pkg::phase_type     phase_ff, phase_in;
   logic                    neg_ff, neg_in;
   logic [31:0]             acc_ff, acc_in;
   logic                    stopped_ff, stopped_in;
   logic [NumF-1:0]         present_ff, present_in;
   logic [NumF-1:0]         bank_ff, bank_in;
   logic [NumF-1:0]         cvalid_ff, cvalid_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_kind_ff;
   logic                    rsp_accepted_ff;
   logic [5:0]              rsp_index_ff;
   logic                    read_hit_ff;
   ctlp_pkg::field_fmt_type read_fmt_ff;
   logic [31:0]             mem_q_ff;
   logic [31:0]             value_mem_ff [MemD];

   logic                    accept;
   logic                    byte_room;
   logic                    is_comma;
   logic                    is_nul;
   logic                    is_digit;
   logic                    is_space;
   logic [31:0]             dval;
   logic [31:0]             acc_x10;
   logic                    field_in_range;
   logic                    do_finish;
   logic [NumF-1:0]         present_set;
   logic [NumF-1:0]         present_all;
   logic [31:0]             fin_val;
   logic [31:0]             fin_trunc;
   logic                    wr_en;
   logic [MemAw-1:0]        wr_addr;
   logic                    rd_en;
   logic [MemAw-1:0]        rd_addr;
   logic                    idx_in_range;
   logic                    line_ok;
   logic                    out_load;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign byte_room = byte_cnt_ff < ByteLimit;
   assign is_comma  = req_data_byte == ctlp_pkg::CharComma;
   assign is_nul    = req_data_byte == ctlp_pkg::CharNul;
   assign is_digit  = (req_data_byte >= ctlp_pkg::CharZero) &&
                      (req_data_byte <= ctlp_pkg::CharNine);
   assign is_space  = (req_data_byte == ctlp_pkg::CharSpace) ||
                      ((req_data_byte >= ctlp_pkg::CharTab) &&
                       (req_data_byte <= ctlp_pkg::CharCr));
   assign dval      = {28'd0, req_data_byte[3:0]};
   assign acc_x10   = {acc_ff[28:0], 3'b000} + {acc_ff[30:0], 1'b0};

   assign field_in_range = field_ff < 6'(NumF);
   assign fin_val   = neg_ff ? (32'd0 - acc_ff) : acc_ff;
   assign fin_trunc = ctlp_pkg::truncate_value(fin_val, ctlp_pkg::field_fmt(field_ff));

   assign do_finish = accept && !stopped_ff &&
                      (((req_op == ctlp_pkg::OP_BYTE) && byte_room && (is_comma || is_nul)) ||
                       (req_op == ctlp_pkg::OP_END));

   always_comb begin
      for (int k = 0; k < NumF; k++) begin
         present_set[k] = do_finish && (field_ff == 6'(k));
      end
   end

   assign present_all = present_ff | present_set;

   assign wr_en   = do_finish && field_in_range;
   assign wr_addr = MemAw'({field_ff, ~bank_ff[field_ff[5:0]]});

   assign idx_in_range = req_reg_index < 6'(NumF);
   assign rd_en   = accept && (req_op == ctlp_pkg::OP_READ) && idx_in_range;
   assign rd_addr = MemAw'({req_reg_index, bank_ff[req_reg_index]});

   assign line_ok = (byte_cnt_ff != '0) && (last_byte_ff == ctlp_pkg::CharNewline) &&
                    (comma_cnt_ff == 9'(ctlp_pkg::NeedCommas));

   assign out_load = accept && ((req_op == ctlp_pkg::OP_END) ||
                                (req_op == ctlp_pkg::OP_READ));

   always_comb begin
      byte_cnt_in  = byte_cnt_ff;
      comma_cnt_in = comma_cnt_ff;
      last_byte_in = last_byte_ff;
      field_in     = field_ff;
      phase_in     = phase_ff;
      neg_in       = neg_ff;
      acc_in       = acc_ff;
      stopped_in   = stopped_ff;
      present_in   = present_ff;
      bank_in      = bank_ff;
      cvalid_in    = cvalid_ff;
      if (accept) begin
         unique case (req_op)
            ctlp_pkg::OP_BYTE: begin
               if (byte_room) begin
                  byte_cnt_in  = byte_cnt_ff + CntW'(1);
                  last_byte_in = req_data_byte;
                  if (is_comma && (comma_cnt_ff != ctlp_pkg::CommaMax)) begin
                     comma_cnt_in = comma_cnt_ff + 9'd1;
                  end
                  if (!stopped_ff) begin
                     if (is_comma) begin
                        present_in = present_all;
                        if (field_in_range) begin
                           field_in = field_ff + 6'd1;
                        end
                        phase_in = ctlp_pkg::PH_WS;
                        neg_in   = 1'b0;
                        acc_in   = '0;
                     end else if (is_nul) begin
                        present_in = present_all;
                        stopped_in = 1'b1;
                     end else begin
                        unique case (phase_ff)
                           ctlp_pkg::PH_WS: begin
                              if (is_space) begin
                                 phase_in = ctlp_pkg::PH_WS;
                              end else if ((req_data_byte == ctlp_pkg::CharMinus) ||
                                           (req_data_byte == ctlp_pkg::CharPlus)) begin
                                 neg_in   = req_data_byte == ctlp_pkg::CharMinus;
                                 phase_in = ctlp_pkg::PH_NUM;
                              end else if (is_digit) begin
                                 acc_in   = dval;
                                 phase_in = ctlp_pkg::PH_NUM;
                              end else begin
                                 phase_in = ctlp_pkg::PH_DONE;
                              end
                           end
                           ctlp_pkg::PH_NUM: begin
                              if (is_digit) begin
                                 acc_in = acc_x10 + dval;
                              end else begin
                                 phase_in = ctlp_pkg::PH_DONE;
                              end
                           end
                           default: begin
                              phase_in = phase_ff;
                           end
                        endcase
                     end
                  end
               end
            end
            ctlp_pkg::OP_END: begin
               if (line_ok) begin
                  bank_in   = bank_ff ^ present_all;
                  cvalid_in = cvalid_ff | present_all;
               end
               byte_cnt_in  = '0;
               comma_cnt_in = '0;
               last_byte_in = '0;
               field_in     = '0;
               phase_in     = ctlp_pkg::PH_WS;
               neg_in       = 1'b0;
               acc_in       = '0;
               stopped_in   = 1'b0;
               present_in   = '0;
            end
            default: begin
               byte_cnt_in = byte_cnt_ff;
            end
         endcase
      end
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_cnt_ff  <= '0;
         comma_cnt_ff <= '0;
         last_byte_ff <= '0;
         field_ff     <= '0;
         phase_ff     <= ctlp_pkg::PH_WS;
         neg_ff       <= 1'b0;
         acc_ff       <= '0;
         stopped_ff   <= 1'b0;
         present_ff   <= '0;
         bank_ff      <= '0;
         cvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         byte_cnt_ff  <= byte_cnt_in;
         comma_cnt_ff <= comma_cnt_in;
         last_byte_ff <= last_byte_in;
         field_ff     <= field_in;
         phase_ff     <= phase_in;
         neg_ff       <= neg_in;
         acc_ff       <= acc_in;
         stopped_ff   <= stopped_in;
         present_ff   <= present_in;
         bank_ff      <= bank_in;
         cvalid_ff    <= cvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_kind_ff     <= req_op == ctlp_pkg::OP_READ;
         rsp_accepted_ff <= (req_op == ctlp_pkg::OP_END) && line_ok;
         rsp_index_ff    <= (req_op == ctlp_pkg::OP_READ) ? req_reg_index : 6'd0;
         read_hit_ff     <= (req_op == ctlp_pkg::OP_READ) && idx_in_range &&
                            cvalid_ff[req_reg_index];
         read_fmt_ff     <= ctlp_pkg::field_fmt(req_reg_index);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         value_mem_ff[wr_addr] <= fin_trunc;
      end
      if (rd_en) begin
         mem_q_ff <= value_mem_ff[rd_addr];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_accepted   = rsp_accepted_ff;
   assign rsp_read_index = rsp_index_ff;
   assign rsp_value      = read_hit_ff ?
                           $signed(ctlp_pkg::extend_value(mem_q_ff, read_fmt_ff)) : 33'sd0;

endmodule

`default_nettype wire

>>> rtl/core/ctlp_checker.sv
// Port-level checker of the telemetry line parser and its bind.
`default_nettype none

`include "assert_macros.svh"

module ctlp_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic [1:0]         req_op,
   input wire logic [5:0]         req_reg_index,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic               rsp_kind,
   input wire logic               rsp_accepted,
   input wire logic signed [32:0] rsp_value,
   input wire logic [5:0]         rsp_read_index
);

   logic        rsp_stall;
   logic [35:0] rsp_word;
   logic        status_rsp;
   logic        read_rsp;
   logic        read_xfer;
   logic        read_beyond;
   logic        value_zero;
   logic        status_zero;
   logic [5:0]  req_index_ff;
   logic        echo_ok;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_word    = {rsp_valid, rsp_kind, rsp_accepted, rsp_value};
   assign status_rsp  = rsp_valid && !rsp_kind;
   assign read_rsp    = rsp_valid && rsp_kind;
   assign read_xfer   = req_valid && req_ready && (req_op == ctlp_pkg::OP_READ);
   assign read_beyond = read_rsp && (rsp_read_index >= 6'(ctlp_pkg::NumFields));
   assign value_zero  = rsp_value == 33'sd0;
   assign status_zero = value_zero && (rsp_read_index == 6'd0);
   assign echo_ok     = rsp_read_index == req_index_ff;

   always_ff @(posedge clock) begin
      req_index_ff <= req_reg_index;
   end

   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_stall, $stable(rsp_word), "stalled transfer changed")
   `CHK_IMPLY(a_status_clean, clock, reset, status_rsp, status_zero, "status carries read data")
   `CHK_IMPLY(a_read_not_accepted, clock, reset, read_rsp, !rsp_accepted, "read marked accepted")
   `CHK_NEXT(a_read_latency, clock, reset, read_xfer, read_rsp && echo_ok, "read result missing")
   `CHK_IMPLY(a_read_beyond_zero, clock, reset, read_beyond, value_zero, "beyond read not zero")

endmodule

bind csv_telemetry_line_parser_core ctlp_checker u_ctlp_checker (.*);

`default_nettype wire

>>> verif/tb_csv_telemetry_line_parser_core.sv
// Self-checking testbench for the CSV telemetry line parser core.
`timescale 1ns / 100ps

module tb_csv_telemetry_line_parser_core;

   localparam int ItemTarget = 1550;
   localparam int CycleLimit = 400000;
   localparam int NumFields  = ctlp_pkg::NumFields;
   localparam int KeepLimit  = ctlp_pkg::BufBytesDefault - 1;

   localparam logic [1:0] OpByte      = ctlp_pkg::OP_BYTE;
   localparam logic [1:0] OpEnd       = ctlp_pkg::OP_END;
   localparam logic [1:0] OpRead      = ctlp_pkg::OP_READ;
   localparam logic [1:0] OpUnused    = 2'd3;
   localparam logic [7:0] CharLetterA = 8'h41;

   localparam ctlp_pkg::field_fmt_type FmtU8  = ctlp_pkg::FT_U8;
   localparam ctlp_pkg::field_fmt_type FmtU16 = ctlp_pkg::FT_U16;
   localparam ctlp_pkg::field_fmt_type FmtS16 = ctlp_pkg::FT_S16;
   localparam ctlp_pkg::field_fmt_type FmtS32 = ctlp_pkg::FT_S32;
   localparam ctlp_pkg::field_fmt_type FmtU32 = ctlp_pkg::FT_U32;

   typedef struct packed {
      logic               kind;
      logic               accepted;
      logic signed [32:0] value;
      logic [5:0]         read_index;
   } readout_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  data;
      logic [5:0]  index;
      logic        typed;
      readout_type want;
   } stim_row_type;

   localparam readout_type NoReply    = '0;
   localparam readout_type LineReject = '{1'b0, 1'b0, 33'sd0, 6'd0};

   localparam ctlp_pkg::field_fmt_type FieldFmt [NumFields] = '{
      FmtU16, FmtU16, FmtS16, FmtU16, FmtS32, FmtU8, FmtU8,
      FmtS16, FmtS16, FmtS16, FmtS16, FmtS16, FmtS16, FmtS16,
      FmtU16, FmtU16, FmtU16, FmtU16, FmtU16, FmtU16, FmtU16,
      FmtU16, FmtU16, FmtU16, FmtU16, FmtU16, FmtU16, FmtU16,
      FmtU16, FmtU16, FmtU16, FmtU16, FmtU16, FmtU16, FmtU16,
      FmtS16, FmtU32, FmtU32
   };

   localparam stim_row_type Directed [20] = '{
      '{OpRead,   8'h00,                 6'd0,  1'b1, '{1'b1, 1'b0, 33'sd0, 6'd0}},
      '{OpRead,   8'hFF,                 6'd37, 1'b1, '{1'b1, 1'b0, 33'sd0, 6'd37}},
      '{OpRead,   8'h00,                 6'd63, 1'b1, '{1'b1, 1'b0, 33'sd0, 6'd63}},
      '{OpEnd,    8'hFF,                 6'd63, 1'b1, LineReject},
      '{OpUnused, 8'hFF,                 6'd63, 1'b0, NoReply},
      '{OpByte,   ctlp_pkg::CharTab,     6'd0,  1'b0, NoReply},
      '{OpByte,   ctlp_pkg::CharMinus,   6'd0,  1'b0, NoReply},
      '{OpByte,   ctlp_pkg::CharNine,    6'd0,  1'b0, NoReply},
      '{OpByte,   ctlp_pkg::CharComma,   6'd0,  1'b0, NoReply},
      '{OpByte,   ctlp_pkg::CharPlus,    6'd0,  1'b0, NoReply},
      '{OpByte,   CharLetterA,           6'd0,  1'b0, NoReply},
      '{OpByte,   ctlp_pkg::CharNul,     6'd0,  1'b0, NoReply},
      '{OpByte,   ctlp_pkg::CharComma,   6'd0,  1'b0, NoReply},
      '{OpByte,   8'hFF,                 6'd0,  1'b0, NoReply},
      '{OpByte,   ctlp_pkg::CharNewline, 6'd0,  1'b0, NoReply},
      '{OpEnd,    8'h00,                 6'd0,  1'b1, LineReject},
      '{OpByte,   ctlp_pkg::CharNewline, 6'd0,  1'b0, NoReply},
      '{OpEnd,    8'h00,                 6'd0,  1'b1, LineReject},
      '{OpRead,   8'h00,                 6'd2,  1'b1, '{1'b1, 1'b0, 33'sd0, 6'd2}},
      '{OpRead,   8'h00,                 6'd38, 1'b1, '{1'b1, 1'b0, 33'sd0, 6'd38}}
   };

   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               req_valid     = 1'b0;
   logic [1:0]         req_op        = OpByte;
   logic [7:0]         req_data_byte = '0;
   logic [5:0]         req_reg_index = '0;
   logic               rsp_ready     = 1'b0;
   logic               req_ready;
   logic               rsp_valid;
   logic               rsp_kind;
   logic               rsp_accepted;
   logic signed [32:0] rsp_value;
   logic [5:0]         rsp_read_index;

   logic        row_typed = 1'b0;
   readout_type row_want  = '0;
   logic        idle_on   = 1'b0;
   logic        calm      = 1'b0;

   logic [31:0]          shadow_val [NumFields];
   logic                 shadow_set [NumFields];
   logic [31:0]          commit_val [NumFields];
   logic [8:0]           n_commas;
   logic [8:0]           n_bytes;
   logic [7:0]           last_byte;
   logic [5:0]           field_no;
   ctlp_pkg::phase_type  phase;
   logic                 neg;
   logic [31:0]          acc;
   logic                 halted;

   readout_type awaited_readouts [$];
   int          items_sent   = 0;
   int          cycles       = 0;
   int          stall_left   = 0;
   bit          failed       = 1'b0;

   csv_telemetry_line_parser_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_data_byte  (req_data_byte),
      .req_reg_index  (req_reg_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_accepted   (rsp_accepted),
      .rsp_value      (rsp_value),
      .rsp_read_index (rsp_read_index)
   );

   always #1 clock = ~clock;

   function automatic void clear_line_state();
      for (int k = 0; k < NumFields; k++) shadow_set[k] = 1'b0;
      n_commas  = '0;
      n_bytes   = '0;
      last_byte = '0;
      field_no  = '0;
      halted    = 1'b0;
      phase     = ctlp_pkg::PH_WS;
      neg       = 1'b0;
      acc       = '0;
   endfunction

   function automatic void close_field();
      logic [31:0] v;
      v = neg ? -acc : acc;
      if (field_no < NumFields) begin
         case (FieldFmt[field_no])
            FmtU8:          v = v & 32'h0000_00FF;
            FmtU16, FmtS16: v = v & 32'h0000_FFFF;
            default:        v = v;
         endcase
         shadow_val[field_no] = v;
         shadow_set[field_no] = 1'b1;
      end
   endfunction

   function automatic void scan_char(input logic [7:0] c);
      logic digit;
      logic blank;
      digit = (c >= ctlp_pkg::CharZero) && (c <= ctlp_pkg::CharNine);
      blank = (c == ctlp_pkg::CharSpace) || ((c >= ctlp_pkg::CharTab) && (c <= ctlp_pkg::CharCr));
      case (phase)
         ctlp_pkg::PH_WS: begin
            if (!blank) begin
               if (c == ctlp_pkg::CharMinus || c == ctlp_pkg::CharPlus) begin
                  neg   = (c == ctlp_pkg::CharMinus);
                  phase = ctlp_pkg::PH_NUM;
               end else if (digit) begin
                  acc   = {24'd0, c - ctlp_pkg::CharZero};
                  phase = ctlp_pkg::PH_NUM;
               end else begin
                  phase = ctlp_pkg::PH_DONE;
               end
            end
         end
         ctlp_pkg::PH_NUM: begin
            if (digit) acc = acc * 32'd10 + {24'd0, c - ctlp_pkg::CharZero};
            else phase = ctlp_pkg::PH_DONE;
         end
         default: phase = ctlp_pkg::PH_DONE;
      endcase
   endfunction

   function automatic logic telemetry_step(input logic [1:0] op, input logic [7:0] c,
                                           input logic [5:0] idx, output readout_type r);
      logic        has;
      logic        ok;
      logic [31:0] v;
      r   = '0;
      has = 1'b0;
      case (op)
         OpByte: begin
            if (n_bytes < KeepLimit) begin
               n_bytes   = n_bytes + 9'd1;
               last_byte = c;
               if (c == ctlp_pkg::CharComma && n_commas < ctlp_pkg::CommaMax)
                  n_commas = n_commas + 9'd1;
               if (!halted) begin
                  if (c == ctlp_pkg::CharComma) begin
                     close_field();
                     if (field_no < NumFields) field_no = field_no + 6'd1;
                     phase = ctlp_pkg::PH_WS;
                     neg   = 1'b0;
                     acc   = '0;
                  end else if (c == ctlp_pkg::CharNul) begin
                     close_field();
                     halted = 1'b1;
                  end else begin
                     scan_char(c);
                  end
               end
            end
         end
         OpEnd: begin
            if (!halted) close_field();
            ok = (n_bytes != 0) && (last_byte == ctlp_pkg::CharNewline) &&
                 (n_commas == ctlp_pkg::NeedCommas);
            if (ok) begin
               for (int k = 0; k < NumFields; k++)
                  if (shadow_set[k]) commit_val[k] = shadow_val[k];
            end
            clear_line_state();
            r.accepted = ok;
            has        = 1'b1;
         end
         OpRead: begin
            r.kind       = 1'b1;
            r.read_index = idx;
            if (idx < NumFields) begin
               v = commit_val[idx];
               case (FieldFmt[idx])
                  FmtS16:  r.value = $signed(v[15:0]);
                  FmtS32:  r.value = $signed(v);
                  default: r.value = $signed({1'b0, v});
               endcase
            end
            has = 1'b1;
         end
         default: has = 1'b0;
      endcase
      return has;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset || calm || !idle_on) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 6);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_and_predict
      readout_type got;
      readout_type want;
      readout_type model_out;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_kind, rsp_accepted, rsp_value, rsp_read_index};
            if (awaited_readouts.size() == 0) begin
               $error("response with none expected: kind %0d", got.kind);
               failed = 1'b1;
            end else begin
               want = awaited_readouts.pop_front();
               if (got.kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, got.kind);
                  failed = 1'b1;
               end
               if (got.accepted !== want.accepted) begin
                  $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
                  failed = 1'b1;
               end
               if (got.value !== want.value) begin
                  $error("value: expected %0d, got %0d", want.value, got.value);
                  failed = 1'b1;
               end
               if (got.read_index !== want.read_index) begin
                  $error("read_index: expected %0d, got %0d", want.read_index, got.read_index);
                  failed = 1'b1;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (telemetry_step(req_op, req_data_byte, req_reg_index, model_out))
               awaited_readouts.push_back(row_typed ? row_want : model_out);
         end
      end
   end

   task automatic put_item(input logic [1:0] op, input logic [7:0] c, input logic [5:0] idx,
                           input logic typed = 1'b0, input readout_type want = '0);
      if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_data_byte <= c;
      req_reg_index <= idx;
      row_typed     <= typed;
      row_want      <= want;
      do @(posedge clock); while (!req_ready);
      if (op != OpUnused) items_sent++;
   endtask

   task automatic send_read();
      logic [5:0] idx;
      idx = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(38, 63))
                                        : 6'($urandom_range(0, NumFields - 1));
      put_item(OpRead, 8'($urandom), idx);
   endtask

   task automatic send_byte(input logic [7:0] c);
      if ($urandom_range(0, 59) == 0) send_read();
      if ($urandom_range(0, 99) == 0) put_item(OpUnused, 8'($urandom), 6'($urandom));
      put_item(OpByte, c, 6'($urandom));
   endtask

   task automatic send_field(input bit sparse);
      longint unsigned edges [14] = '{64'd0, 64'd127, 64'd128, 64'd255, 64'd256, 64'd32767,
                                      64'd32768, 64'd65535, 64'd65536, 64'd2147483647,
                                      64'd2147483648, 64'd4294967295, 64'd4294967296,
                                      64'd9999999999};
      string digits;
      int    pick;
      int    w;
      pick = (sparse && $urandom_range(0, 7) != 0) ? 0 : $urandom_range(0, 9);
      if (pick != 0 && $urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            w = $urandom_range(0, 5);
            send_byte((w == 0) ? ctlp_pkg::CharSpace : ctlp_pkg::CharTab + 8'(w - 1));
         end
      end
      if (pick != 0) begin
         w = $urandom_range(0, 5);
         if (w < 2) send_byte(ctlp_pkg::CharMinus);
         else if (w == 2) send_byte(ctlp_pkg::CharPlus);
      end
      case (pick)
         0, 1, 2: digits = "";
         3, 4, 5: digits = $sformatf("%0d", $urandom_range(0, 99));
         6:       digits = $sformatf("%0d", $urandom);
         7:       digits = $sformatf("%0d", edges[$urandom_range(0, 13)]);
         8:       digits = $sformatf("%0d%0d", $urandom_range(10000, 99999), $urandom);
         default: begin
            send_byte(CharLetterA + 8'($urandom_range(0, 25)));
            digits = "12";
         end
      endcase
      for (int i = 0; i < digits.len(); i++) send_byte(digits[i]);
      if (pick != 0 && $urandom_range(0, 7) == 0)
         send_byte(CharLetterA + 8'($urandom_range(0, 25)));
   endtask

   task automatic send_line(input int shape, input bit pad);
      int n_fields;
      int nul_at;
      bit sparse;
      n_fields = NumFields;
      sparse   = pad || $urandom_range(0, 1);
      nul_at   = ($urandom_range(0, 5) == 0) ? $urandom_range(0, NumFields - 1) : -1;
      if (shape == 1)
         n_fields = ($urandom_range(0, 2) == 0) ? NumFields - 1
                                                : $urandom_range(NumFields + 1, NumFields + 6);
      if (shape == 3) begin
         repeat ($urandom_range(1, 60)) send_byte(8'($urandom));
      end else begin
         if (pad) repeat ($urandom_range(400, 470))
            send_byte($urandom_range(0, 1) ? ctlp_pkg::CharSpace : ctlp_pkg::CharTab);
         for (int f = 0; f < n_fields; f++) begin
            if (f > 0) send_byte(ctlp_pkg::CharComma);
            send_field(sparse);
            if (f == nul_at) begin
               send_byte(ctlp_pkg::CharNul);
               send_byte(ctlp_pkg::CharNine);
            end
         end
         if (shape != 2) begin
            send_byte(ctlp_pkg::CharNewline);
         end else if ($urandom_range(0, 1)) begin
            send_byte(ctlp_pkg::CharNewline);
            send_byte($urandom_range(0, 1) ? ctlp_pkg::CharSpace : ctlp_pkg::CharCr);
         end
      end
      put_item(OpEnd, 8'($urandom), 6'($urandom));
      repeat ($urandom_range(0, 4)) send_read();
   endtask

   initial begin
      int line_no;
      int r;
      for (int k = 0; k < NumFields; k++) begin
         shadow_val[k] = '0;
         commit_val[k] = '0;
      end
      clear_line_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(Directed); i++)
         put_item(Directed[i].op, Directed[i].data, Directed[i].index,
                  Directed[i].typed, Directed[i].want);

      line_no = 0;
      while (items_sent < ItemTarget) begin
         idle_on <= ($urandom_range(0, 3) != 0);
         if (items_sent >= ItemTarget - 250) calm <= 1'b1;
         if ($urandom_range(0, 9) == 0) put_item(OpEnd, 8'($urandom), 6'($urandom));
         r = $urandom_range(0, 19);
         send_line((r < 13) ? 0 : (r < 16) ? 1 : (r < 18) ? 2 : 3, line_no == 2);
         line_no++;
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_readouts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (!failed) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
